[sv/esv_pkg.sv]
// Shared types and constants of the ElGamal sign and verify unit.
`timescale 1ns / 1ps
package esv_pkg;

  localparam int W = 16;
  localparam int W2 = 2 * W;
  localparam int CW = W + 3;
  localparam int DCW = $clog2(W2 + 1);

  localparam logic [1:0] CFG_MODULUS = 2'd0;
  localparam logic [1:0] CFG_GENERATOR = 2'd1;
  localparam logic [1:0] CFG_PRIVATE = 2'd2;
  localparam logic [1:0] CFG_PUBLIC = 2'd3;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_HASH = 2'd1;
  localparam logic [1:0] ST_NONCE = 2'd2;
  localparam logic [1:0] ST_COPRIME = 2'd3;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_EUC_INIT,
    OP_EUC_DIV,
    OP_EUC_UPD,
    OP_EUC_UPD2,
    OP_EUC_FIN,
    OP_POW_GK,
    OP_POW_YR,
    OP_POW_RS,
    OP_POW_GM,
    OP_MUL_ACC,
    OP_MUL_SQR,
    OP_MUL_T1,
    OP_SAVE_R,
    OP_SAVE_T1,
    OP_MUL_XR,
    OP_DIFF,
    OP_MUL_S
  } op_t;

  typedef struct packed {
    op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;
    logic exp_zero;
    logic exp_lsb;
    logic r_zero;
    logic gcd_one;
    logic is_verify;
    logic chk_err;
    logic vrange;
  } dp_stat_t;

endpackage

[sv/esv_div.sv]
// Iterative restoring divider: one quotient bit per cycle.
`timescale 1ns / 1ps
module esv_div import esv_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [W2-1:0] dividend,
  input  logic [W-1:0]  divisor,
  output logic          done,
  output logic [W2-1:0] quot,
  output logic [W-1:0]  rem
);

  logic           busy;
  logic [DCW-1:0] cnt;
  logic [W-1:0]   dsr;
  logic [W:0]     trial;

  assign trial = {rem, quot[W2-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= DCW'(W2);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == DCW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // quot holds the shrinking dividend and the growing quotient together
  always_ff @(posedge clk) begin
    if (start) begin
      quot <= dividend;
      rem <= '0;
      dsr <= divisor;
    end else if (busy) begin
      if (trial >= {1'b0, dsr}) begin
        rem <= W'(trial - {1'b0, dsr});
        quot <= {quot[W2-2:0], 1'b1};
      end else begin
        rem <= W'(trial);
        quot <= {quot[W2-2:0], 1'b0};
      end
    end
  end

endmodule

[sv/esv_dp.sv]
// Datapath: registers, input latch, shared modular multiplier and Euclid state.
`timescale 1ns / 1ps
module esv_dp import esv_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_valid,
  input  logic [1:0]   cfg_index,
  input  logic [W-1:0] cfg_data,
  input  logic         command,
  input  logic [W-1:0] message_hash,
  input  logic [W-1:0] nonce,
  input  logic [W-1:0] sig_r_in,
  input  logic [W-1:0] sig_s_in,
  input  dp_cmd_t      cmd,
  output dp_stat_t     stat,
  output logic [W-1:0] res_r,
  output logic [W-1:0] res_s,
  output logic         res_valid,
  output logic [1:0]   res_status
);

  typedef enum logic [1:0] {D_ACC, D_BAS, D_Q} dest_t;

  logic [W-1:0] modulus, generator, private_key, public_key;
  logic         in_cmd;
  logic [W-1:0] in_m, in_k, in_r, in_s;
  logic [W-1:0] acc, bas, expo, rsig, t1, q, rem_r, old_r, rr;
  logic signed [CW-1:0] oc, cc, qc, nn_s;
  dest_t        dest;

  logic          div_start, div_done;
  logic [W2-1:0] div_dvd, div_quot;
  logic [W-1:0]  div_dsr, div_rem, n;
  logic          chk_hash, chk_nonce, vrange, sign_ok;

  assign n = modulus - 1'b1;
  assign nn_s = signed'({{(CW - W){1'b0}}, n});

  esv_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(div_dvd),
    .divisor(div_dsr), .done(div_done), .quot(div_quot), .rem(div_rem)
  );

  always_comb begin
    div_start = 1'b0;
    div_dvd = '0;
    div_dsr = modulus;
    case (cmd.op)
      OP_MUL_ACC: begin
        div_start = 1'b1;
        div_dvd = W2'(acc) * W2'(bas);
      end
      OP_MUL_SQR: begin
        div_start = 1'b1;
        div_dvd = W2'(bas) * W2'(bas);
      end
      OP_MUL_T1: begin
        div_start = 1'b1;
        div_dvd = W2'(acc) * W2'(t1);
      end
      OP_MUL_XR: begin
        div_start = 1'b1;
        div_dvd = W2'(private_key) * W2'(rsig);
        div_dsr = n;
      end
      OP_MUL_S: begin
        div_start = 1'b1;
        div_dvd = W2'(acc) * W2'(t1);
        div_dsr = n;
      end
      OP_EUC_DIV: begin
        div_start = 1'b1;
        div_dvd = W2'(old_r);
        div_dsr = rr;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= W'(3);
      generator <= W'(2);
      private_key <= W'(2);
      public_key <= W'(1);
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_MODULUS:   modulus <= cfg_data;
        CFG_GENERATOR: generator <= cfg_data;
        CFG_PRIVATE:   private_key <= cfg_data;
        CFG_PUBLIC:    public_key <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (div_done) begin
      case (dest)
        D_ACC: acc <= div_rem;
        D_BAS: begin
          bas <= div_rem;
          expo <= expo >> 1;
        end
        D_Q: begin
          q <= div_quot[W-1:0];
          rem_r <= div_rem;
        end
        default: ;
      endcase
    end
    case (cmd.op)
      OP_LOAD: begin
        in_cmd <= command;
        in_m <= message_hash;
        in_k <= nonce;
        in_r <= sig_r_in;
        in_s <= sig_s_in;
      end
      OP_EUC_INIT: begin
        old_r <= (in_k == n) ? '0 : in_k;
        rr <= n;
        oc <= CW'(1);
        cc <= '0;
      end
      OP_EUC_DIV: dest <= D_Q;
      OP_EUC_UPD: begin
        old_r <= rr;
        rr <= rem_r;
        qc <= CW'(signed'({1'b0, q}) * cc);
      end
      OP_EUC_UPD2: begin
        oc <= cc;
        cc <= oc - qc;
      end
      OP_EUC_FIN: begin
        if (oc < 0) t1 <= W'(oc + nn_s);
        else if (oc >= nn_s) t1 <= W'(oc - nn_s);
        else t1 <= W'(oc);
      end
      OP_POW_GK: begin
        acc <= W'(1);
        bas <= generator;
        expo <= in_k;
      end
      OP_POW_YR: begin
        acc <= W'(1);
        bas <= public_key;
        expo <= in_r;
      end
      OP_POW_RS: begin
        acc <= W'(1);
        bas <= in_r;
        expo <= in_s;
      end
      OP_POW_GM: begin
        acc <= W'(1);
        bas <= generator;
        expo <= in_m;
      end
      OP_MUL_ACC, OP_MUL_T1, OP_MUL_XR, OP_MUL_S: dest <= D_ACC;
      OP_MUL_SQR: dest <= D_BAS;
      OP_SAVE_R: rsig <= acc;
      OP_SAVE_T1: t1 <= acc;
      OP_DIFF: begin
        if (in_m >= acc) acc <= in_m - acc;
        else acc <= W'({1'b0, in_m} + {1'b0, n} - {1'b0, acc});
      end
      default: ;
    endcase
  end

  assign chk_hash = (modulus <= W'(3)) || (in_m <= W'(1)) || (in_m >= n);
  assign chk_nonce = (in_k == '0) || (in_k > n);
  assign vrange = (modulus >= W'(2)) && (in_r != '0) && (in_r <= n) && (in_s < n);

  always_comb begin
    if (in_cmd) res_status = ST_OK;
    else if (chk_hash) res_status = ST_HASH;
    else if (chk_nonce) res_status = ST_NONCE;
    else if (old_r != W'(1)) res_status = ST_COPRIME;
    else res_status = ST_OK;
  end

  assign sign_ok = !in_cmd && (res_status == ST_OK);
  assign res_r = sign_ok ? rsig : '0;
  assign res_s = sign_ok ? acc : '0;
  assign res_valid = in_cmd && vrange && (acc == t1);

  always_comb begin
    stat.div_done = div_done;
    stat.exp_zero = (expo == '0);
    stat.exp_lsb = expo[0];
    stat.r_zero = (rr == '0);
    stat.gcd_one = (old_r == W'(1));
    stat.is_verify = in_cmd;
    stat.chk_err = chk_hash || chk_nonce;
    stat.vrange = vrange;
  end

endmodule

[sv/esv_ctrl.sv]
// Controller: sequences Euclid, exponentiations and products on the datapath.
`timescale 1ns / 1ps
module esv_ctrl import esv_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  logic     out_free,
  output logic     load_out,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [20:0] {
    S_IDLE  = 21'h000001,
    S_CHECK = 21'h000002,
    S_EDIV  = 21'h000004,
    S_EWAIT = 21'h000008,
    S_EUPD  = 21'h000010,
    S_EUPD2 = 21'h000020,
    S_ELOOP = 21'h000040,
    S_GCD   = 21'h000080,
    S_PINIT = 21'h000100,
    S_PCHK  = 21'h000200,
    S_PACCW = 21'h000400,
    S_PSQR  = 21'h000800,
    S_PSQRW = 21'h001000,
    S_XR    = 21'h002000,
    S_XRW   = 21'h004000,
    S_DIFF  = 21'h008000,
    S_MS    = 21'h010000,
    S_MSW   = 21'h020000,
    S_T1W   = 21'h040000,
    S_T1S   = 21'h080000,
    S_FIN   = 21'h100000
  } state_t;

  typedef enum logic [1:0] {PH_GK, PH_YR, PH_RS, PH_GM} ph_t;

  state_t state, state_next;
  ph_t    phase, phase_next;

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      phase <= PH_GK;
    end else begin
      state <= state_next;
      phase <= phase_next;
    end
  end

  always_comb begin
    state_next = state;
    phase_next = phase;
    cmd.op = OP_NONE;
    load_out = 1'b0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op = OP_LOAD;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat.is_verify) begin
          if (stat.vrange) begin
            phase_next = PH_YR;
            state_next = S_PINIT;
          end else begin
            state_next = S_FIN;
          end
        end else if (stat.chk_err) begin
          state_next = S_FIN;
        end else begin
          cmd.op = OP_EUC_INIT;
          state_next = S_EDIV;
        end
      end
      S_EDIV: begin
        cmd.op = OP_EUC_DIV;
        state_next = S_EWAIT;
      end
      S_EWAIT: if (stat.div_done) state_next = S_EUPD;
      S_EUPD: begin
        cmd.op = OP_EUC_UPD;
        state_next = S_EUPD2;
      end
      S_EUPD2: begin
        cmd.op = OP_EUC_UPD2;
        state_next = S_ELOOP;
      end
      S_ELOOP: begin
        if (stat.r_zero) begin
          cmd.op = OP_EUC_FIN;
          state_next = S_GCD;
        end else begin
          state_next = S_EDIV;
        end
      end
      S_GCD: begin
        if (stat.gcd_one) begin
          phase_next = PH_GK;
          state_next = S_PINIT;
        end else begin
          state_next = S_FIN;
        end
      end
      S_PINIT: begin
        case (phase)
          PH_GK:   cmd.op = OP_POW_GK;
          PH_YR:   cmd.op = OP_POW_YR;
          PH_RS:   cmd.op = OP_POW_RS;
          PH_GM:   cmd.op = OP_POW_GM;
          default: cmd.op = OP_NONE;
        endcase
        state_next = S_PCHK;
      end
      S_PCHK: begin
        if (!stat.exp_zero) begin
          if (stat.exp_lsb) begin
            cmd.op = OP_MUL_ACC;
            state_next = S_PACCW;
          end else begin
            cmd.op = OP_MUL_SQR;
            state_next = S_PSQRW;
          end
        end else begin
          case (phase)
            PH_GK: begin
              cmd.op = OP_SAVE_R;
              state_next = S_XR;
            end
            PH_YR: begin
              cmd.op = OP_SAVE_T1;
              phase_next = PH_RS;
              state_next = S_PINIT;
            end
            PH_RS: begin
              cmd.op = OP_MUL_T1;
              state_next = S_T1W;
            end
            default: state_next = S_FIN;
          endcase
        end
      end
      S_PACCW: if (stat.div_done) state_next = S_PSQR;
      S_PSQR: begin
        cmd.op = OP_MUL_SQR;
        state_next = S_PSQRW;
      end
      S_PSQRW: if (stat.div_done) state_next = S_PCHK;
      S_XR: begin
        cmd.op = OP_MUL_XR;
        state_next = S_XRW;
      end
      S_XRW: if (stat.div_done) state_next = S_DIFF;
      S_DIFF: begin
        cmd.op = OP_DIFF;
        state_next = S_MS;
      end
      S_MS: begin
        cmd.op = OP_MUL_S;
        state_next = S_MSW;
      end
      S_MSW: if (stat.div_done) state_next = S_FIN;
      S_T1W: if (stat.div_done) state_next = S_T1S;
      S_T1S: begin
        cmd.op = OP_SAVE_T1;
        phase_next = PH_GM;
        state_next = S_PINIT;
      end
      S_FIN: begin
        if (out_free) begin
          load_out = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

[sv/elgamal_sign_verify_core.sv]
// Top level of the ElGamal sign and verify unit.
`timescale 1ns / 1ps
// Usage:
//   cfg channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes modulus (0),
//   generator (1), private_key (2) and public_key (3); cfg_ready is always high.
//   Write configuration only while no request is in flight.
//   in channel (in_valid/in_ready) takes one request: command 0 signs
//   message_hash with nonce, command 1 verifies sig_r_in/sig_s_in.
//   out channel (out_valid/out_ready) returns one result per request:
//   sig_r_out, sig_s_out, sig_valid and status.
// Sequencing:
//   One request at a time. Every modular product runs through one shared
//   multiplier followed by a 32-step restoring divider. An exponentiation
//   costs one product per exponent bit plus one per set bit. Signing adds
//   an extended Euclid pass with one divider run per quotient step. A
//   request with a range error runs no product; the longest request is a
//   full verify with three 16-bit exponents.
// Reset: rst clears control state and loads the register defaults
//   (3, 2, 2, 1); no result is pending afterward.
// Stall: a finished result sits in the output register; while it is full and
//   out_ready is low the core holds the next result in its final state and takes no request.
module elgamal_sign_verify_core import esv_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [W-1:0] cfg_data,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic         command,
  input  logic [W-1:0] message_hash,
  input  logic [W-1:0] nonce,
  input  logic [W-1:0] sig_r_in,
  input  logic [W-1:0] sig_s_in,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [W-1:0] sig_r_out,
  output logic [W-1:0] sig_s_out,
  output logic         sig_valid,
  output logic [1:0]   status
);

  dp_cmd_t      cmd;
  dp_stat_t     stat;
  logic         load_out, out_free;
  logic [W-1:0] res_r, res_s;
  logic         res_valid;
  logic [1:0]   res_status;

  assign cfg_ready = 1'b1;
  // the output slot frees when empty or being drained this cycle
  assign out_free = !out_valid || out_ready;

  esv_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .out_free(out_free), .load_out(load_out), .stat(stat), .cmd(cmd)
  );

  esv_dp u_dp (
    .clk(clk), .rst(rst), .cfg_valid(cfg_valid), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .command(command), .message_hash(message_hash),
    .nonce(nonce), .sig_r_in(sig_r_in), .sig_s_in(sig_s_in), .cmd(cmd),
    .stat(stat), .res_r(res_r), .res_s(res_s), .res_valid(res_valid),
    .res_status(res_status)
  );

  // hold the result until the receiver takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      sig_r_out <= res_r;
      sig_s_out <= res_s;
      sig_valid <= res_valid;
      status <= res_status;
    end
  end

endmodule

[dv/elgamal_sign_verify_core_tb.sv]
// Testbench for the ElGamal sign and verify unit: it predicts every result and checks it.
`timescale 1ns / 1ps
module elgamal_sign_verify_core_tb;
  import esv_pkg::*;

  // One result of the unit, as the predictor works it out.
  typedef struct {
    logic [W-1:0] r;
    logic [W-1:0] s;
    logic         ok;
    logic [1:0]   st;
  } sig_result_t;

  // Scoreboard: hold the register copy, predict each accepted request and
  // check results against the oldest prediction.
  class elgamal_scoreboard;
    logic [W-1:0] p_reg, g_reg, x_reg, y_reg;
    sig_result_t  pending[$];
    int           errors;
    int           checked;
    int           n_sign_ok;
    int           n_valid;
    int           n_err_st[4];

    function void reset_regs();
      p_reg = 3;
      g_reg = 2;
      x_reg = 2;
      y_reg = 1;
    endfunction

    function void write_reg(logic [1:0] idx, logic [W-1:0] val);
      case (idx)
        CFG_MODULUS:   p_reg = val;
        CFG_GENERATOR: g_reg = val;
        CFG_PRIVATE:   x_reg = val;
        CFG_PUBLIC:    y_reg = val;
        default: ;
      endcase
    endfunction

    function longint unsigned mulmod(longint unsigned a, longint unsigned b,
                                     longint unsigned n);
      return ((a % n) * (b % n)) % n;
    endfunction

    function longint unsigned powmod(longint unsigned b, longint unsigned e,
                                     longint unsigned n);
      longint unsigned acc;
      longint unsigned sq;
      acc = 1 % n;
      sq = b % n;
      while (e != 0) begin
        if (e[0]) acc = mulmod(acc, sq, n);
        sq = mulmod(sq, sq, n);
        e = e >> 1;
      end
      return acc;
    endfunction

    function longint unsigned gcd_val(longint unsigned a, longint unsigned b);
      longint unsigned t;
      while (b != 0) begin
        t = a % b;
        a = b;
        b = t;
      end
      return a;
    endfunction

    function longint unsigned inverse(longint unsigned a, longint unsigned n);
      longint r0, r1, c0, c1, q, t;
      r0 = a % n;
      r1 = n;
      c0 = 1;
      c1 = 0;
      while (r1 != 0) begin
        q = r0 / r1;
        t = r0 - q * r1;
        r0 = r1;
        r1 = t;
        t = c0 - q * c1;
        c0 = c1;
        c1 = t;
      end
      c0 = c0 % longint'(n);
      if (c0 < 0) c0 += longint'(n);
      return c0;
    endfunction

    function void note_request(logic cmd, logic [W-1:0] m, logic [W-1:0] k,
                               logic [W-1:0] rin, logic [W-1:0] sin);
      sig_result_t e;
      longint unsigned p, n, r, xr, diff, lhs;
      p = p_reg;
      e.r = '0;
      e.s = '0;
      e.ok = 1'b0;
      e.st = ST_OK;
      if (cmd == 1'b0) begin
        if (p <= 3 || m <= 1 || m >= p - 1) e.st = ST_HASH;
        else if (k < 1 || k > p - 1) e.st = ST_NONCE;
        else if (gcd_val(k, p - 1) != 1) e.st = ST_COPRIME;
        else begin
          n = p - 1;
          r = powmod(g_reg, k, p);
          xr = mulmod(x_reg, r, n);
          diff = ((m % n) + n - xr) % n;
          e.r = r[W-1:0];
          e.s = W'(mulmod(diff, inverse(k, n), n));
          n_sign_ok++;
        end
        n_err_st[e.st]++;
      end else if (p >= 2 && rin >= 1 && rin <= p - 1 && sin <= p - 2) begin
        lhs = mulmod(powmod(y_reg, rin, p), powmod(rin, sin, p), p);
        e.ok = (lhs == powmod(g_reg, m, p));
        if (e.ok) n_valid++;
      end
      pending.push_back(e);
    endfunction

    function void check_result(logic [W-1:0] r, logic [W-1:0] s, logic v,
                               logic [1:0] st);
      sig_result_t e;
      if (pending.size() == 0) begin
        $error("result with no request waiting");
        errors++;
        return;
      end
      e = pending.pop_front();
      checked++;
      if (r !== e.r) begin
        $error("sig_r_out expected %0d actual %0d", e.r, r);
        errors++;
      end
      if (s !== e.s) begin
        $error("sig_s_out expected %0d actual %0d", e.s, s);
        errors++;
      end
      if (v !== e.ok) begin
        $error("sig_valid expected %0d actual %0d", e.ok, v);
        errors++;
      end
      if (st !== e.st) begin
        $error("status expected %0d actual %0d", e.st, st);
        errors++;
      end
    endfunction
  endclass

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [1:0]   cfg_index = CFG_MODULUS;
  logic [W-1:0] cfg_data = '0;
  logic         in_valid = 1'b0;
  logic         in_ready;
  logic         command = 1'b0;
  logic [W-1:0] message_hash = '0;
  logic [W-1:0] nonce = '0;
  logic [W-1:0] sig_r_in = '0;
  logic [W-1:0] sig_s_in = '0;
  logic         out_valid;
  logic         out_ready = 1'b0;
  logic [W-1:0] sig_r_out;
  logic [W-1:0] sig_s_out;
  logic         sig_valid;
  logic [1:0]   status;

  elgamal_scoreboard sb;

  always #5 clk = ~clk;

  elgamal_sign_verify_core dut (.*);

  // Mostly short gaps, now and then a long one, sometimes none at all.
  function automatic int gap_len();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 40) return 0;
    if (sel < 90) return $urandom_range(1, 4);
    return $urandom_range(20, 400);
  endfunction

  // Write one register while the unit is idle.
  task automatic write_cfg(logic [1:0] idx, logic [W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, val);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Present one request and hold it until the unit takes it; valid drops
  // only when a gap follows.
  task automatic send_request(logic cmd, logic [W-1:0] m, logic [W-1:0] k,
                              logic [W-1:0] rin, logic [W-1:0] sin);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    command <= cmd;
    message_hash <= m;
    nonce <= k;
    sig_r_in <= rin;
    sig_s_in <= sin;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_request(cmd, m, k, rin, sin);
  endtask

  // Let the unit drain before touching the registers again.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic load_key(logic [W-1:0] p, logic [W-1:0] g, logic [W-1:0] x);
    wait_idle();
    write_cfg(CFG_MODULUS, p);
    write_cfg(CFG_GENERATOR, g);
    write_cfg(CFG_PRIVATE, x);
    write_cfg(CFG_PUBLIC, W'(sb.powmod(g, x, p)));
  endtask

  // Sign then verify the fresh pair, sometimes with a bit flipped.
  task automatic sign_and_verify(logic [W-1:0] m, logic [W-1:0] k);
    sig_result_t e;
    logic [W-1:0] rr, ss;
    send_request(1'b0, m, k, W'($urandom), W'($urandom));
    e = sb.pending[$];
    rr = e.r;
    ss = e.s;
    if ($urandom_range(0, 3) == 0) ss ^= W'(1) << $urandom_range(0, W - 1);
    send_request(1'b1, m, W'($urandom), rr, ss);
  endtask

  // Random traffic under the current key: mostly good pairs, plus noise.
  task automatic random_phase(int count);
    logic [W-1:0] p, m, k;
    int sel;
    p = sb.p_reg;
    for (int i = 0; i < count; i++) begin
      sel = $urandom_range(0, 9);
      m = (p > 4) ? W'($urandom_range(2, p - 2)) : W'($urandom);
      k = (p > 2) ? W'($urandom_range(1, p - 1)) : W'($urandom);
      if (sel < 6) begin
        sign_and_verify(m, k);
        i++;
      end else if (sel < 8) begin
        send_request(1'b0, W'($urandom), W'($urandom), W'($urandom), W'($urandom));
      end else begin
        send_request(1'b1, W'($urandom), W'($urandom), W'($urandom), W'($urandom));
      end
    end
  endtask

  // Result side: stall at random, check each accepted result.
  initial begin
    int g;
    @(negedge rst);
    forever begin
      g = gap_len();
      if (g > 0) begin
        out_ready <= 1'b0;
        repeat (g) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      sb.check_result(sig_r_out, sig_s_out, sig_valid, status);
    end
  end

  initial begin
    sb = new();
    sb.reset_regs();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset key: p = 3 turns every sign into a hash range error.
    send_request(1'b0, 16'd2, 16'd1, 16'd0, 16'd0);
    send_request(1'b1, 16'd0, 16'd0, 16'd1, 16'd0);

    // Small prime: hit every status and the verify range edges.
    load_key(16'd23, 16'd5, 16'd7);
    send_request(1'b0, 16'd1, 16'd3, 16'd0, 16'd0);     // hash too low
    send_request(1'b0, 16'd22, 16'd3, 16'd0, 16'd0);    // hash at p-1
    send_request(1'b0, 16'hFFFF, 16'd3, 16'd0, 16'd0);  // hash all ones
    send_request(1'b0, 16'd5, 16'd0, 16'd0, 16'd0);     // nonce zero
    send_request(1'b0, 16'd5, 16'd23, 16'd0, 16'd0);    // nonce at p
    send_request(1'b0, 16'd5, 16'hFFFF, 16'd0, 16'd0);  // nonce all ones
    send_request(1'b0, 16'd5, 16'd2, 16'd0, 16'd0);     // nonce shares factor
    sign_and_verify(16'd2, 16'd1);
    sign_and_verify(16'd21, 16'd21);
    send_request(1'b1, 16'd5, 16'd0, 16'd0, 16'd3);     // r zero
    send_request(1'b1, 16'd5, 16'd0, 16'd23, 16'd3);    // r at p
    send_request(1'b1, 16'd5, 16'd0, 16'd3, 16'd22);    // s at p-1
    send_request(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_request(1'b1, 16'd0, 16'd0, 16'd1, 16'd0);     // s and m exponents zero

    // Largest 16-bit prime with the full-width fields.
    load_key(16'd65521, 16'd17, 16'd65519);
    sign_and_verify(16'd65519, 16'd65519);
    sign_and_verify(16'd2, 16'd1);

    // Broken registers: composite p, g at p - 1, mismatched y, tiny p.
    wait_idle();
    write_cfg(CFG_MODULUS, 16'd1);
    send_request(1'b1, 16'd3, 16'd0, 16'd1, 16'd0);
    wait_idle();
    write_cfg(CFG_MODULUS, 16'hFFFF);
    write_cfg(CFG_GENERATOR, 16'hFFFE);
    write_cfg(CFG_PUBLIC, 16'h0000);
    random_phase(40);

    // Random phases over a spread of keys, mostly small moduli for speed.
    for (int ph = 0; ph < 14; ph++) begin
      case (ph % 7)
        0: load_key(16'd5, 16'd2, 16'd3);
        1: load_key(16'd101, 16'd2, 16'd37);
        2: load_key(16'd257, 16'd3, 16'd200);
        3: load_key(16'd65521, W'($urandom_range(2, 65519)), W'($urandom_range(2, 65519)));
        4: load_key(16'd32749, 16'd2, W'($urandom_range(2, 32747)));
        5: load_key(16'd11, 16'd2, 16'd10);
        default: load_key(W'($urandom_range(3, 65535)), W'($urandom), W'($urandom));
      endcase
      random_phase((ph % 7 == 3) ? 30 : 80);
    end

    wait_idle();
    $display("Checked %0d results: %0d good signatures, %0d verified valid.",
             sb.checked, sb.n_sign_ok, sb.n_valid);
    $display("Sign statuses hash/nonce/coprime: %0d/%0d/%0d.",
             sb.n_err_st[1], sb.n_err_st[2], sb.n_err_st[3]);
    if (sb.errors == 0) begin
      $display("elgamal_sign_verify_core test passed");
    end else begin
      $display("elgamal_sign_verify_core test failed");
    end
    $finish;
  end

  // Guard against a hung unit.
  initial begin
    #200ms;
    $display("elgamal_sign_verify_core test failed");
    $finish;
  end

endmodule

[elgamal_sign_verify_core.f]
sv/esv_pkg.sv
sv/esv_div.sv
sv/esv_dp.sv
sv/esv_ctrl.sv
sv/elgamal_sign_verify_core.sv
dv/elgamal_sign_verify_core_tb.sv
